// ----- rtl/core/vrdw_pkg.sv -----
// Shared constants, types and helpers for the voxel ray DDA walker.
package vrdw_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int ORG_W       = 32;
    localparam int HEAD_W      = 18;
    localparam int MAG_W       = 18;
    localparam int CELL_W      = 16;
    localparam int DIST_W      = 32;
    localparam int REACH_W     = 24;
    localparam int FACE_W      = 3;
    localparam int SUM_W       = 2 * MAG_W;
    localparam int LEN_W       = SUM_W / 2;
    localparam int NUM_W       = LEN_W + FRAC_BITS;
    localparam int REM_W       = MAG_W + 1;
    localparam int FDIST_W     = FRAC_BITS + 1;
    localparam int MUL_A_W     = (FDIST_W > MAG_W) ? FDIST_W : MAG_W;
    localparam int PROD_W      = MUL_A_W + DIST_W;
    localparam int SQRT_ITERS  = SUM_W / 2;
    localparam int DIV_ITERS   = NUM_W;
    localparam int CNT_W       = 6;
    localparam int AX_W        = 2;
    localparam int S_DATA_W    = 152;
    localparam int M_DATA_W    = 56;

    localparam logic [REACH_W-1:0] REACH_RESET = REACH_W'(3 << FRAC_BITS);

    localparam logic [AX_W-1:0] AX_X = 2'd0;
    localparam logic [AX_W-1:0] AX_Y = 2'd1;
    localparam logic [AX_W-1:0] AX_Z = 2'd2;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;
    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_RESULT = 1'b1;

    localparam logic [FACE_W-1:0] FACE_DOWN  = 3'd0;
    localparam logic [FACE_W-1:0] FACE_UP    = 3'd1;
    localparam logic [FACE_W-1:0] FACE_BACK  = 3'd2;
    localparam logic [FACE_W-1:0] FACE_FRONT = 3'd3;
    localparam logic [FACE_W-1:0] FACE_LEFT  = 3'd4;
    localparam logic [FACE_W-1:0] FACE_RIGHT = 3'd5;

    typedef struct packed {
        logic            load;
        logic            mul_sq;
        logic            sq_acc;
        logic            sqrt_init;
        logic            sqrt_step;
        logic            div_init;
        logic            div_step;
        logic            div_end;
        logic            side_wr;
        logic            finish;
        logic            start;
        logic [AX_W-1:0] axis;
    } vrdw_cmd_t;

    typedef struct packed {
        logic walk_active;
        logic out_free;
    } vrdw_status_t;

    function automatic logic [FACE_W-1:0] face_code(input logic [AX_W-1:0] ax, input logic neg);
        logic [FACE_W-1:0] f;
        unique case (ax)
            AX_X:    f = neg ? FACE_RIGHT : FACE_LEFT;
            AX_Y:    f = neg ? FACE_UP    : FACE_DOWN;
            default: f = neg ? FACE_FRONT : FACE_BACK;
        endcase
        return f;
    endfunction

endpackage

// ----- rtl/core/vrdw_ctrl.sv -----
// Sequencer for ray setup (squares, root, divisions, side distances) and walk steps.
module vrdw_ctrl
    import vrdw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         op,
    input  vrdw_status_t status,
    output logic         s_tready,
    output vrdw_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_END,
        S_SIDE_MUL, S_SIDE_WR, S_FIN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [AX_W-1:0]  ax_reg;
    logic             start_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ax_reg    <= AX_X;
            start_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        start_reg <= (op == OP_START);
                        cnt_reg   <= '0;
                        if (op == OP_START) begin
                            state_reg <= S_SQ;
                        end else if (status.walk_active) begin
                            state_reg <= S_FIN;
                        end
                    end
                end
                S_SQ: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(3)) begin
                        state_reg <= S_SQRT_INIT;
                    end
                end
                S_SQRT_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SQRT_ITERS - 1)) begin
                        ax_reg    <= AX_X;
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_DIV_INIT: begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_ITERS - 1)) begin
                        state_reg <= S_DIV_END;
                    end
                end
                S_DIV_END:  state_reg <= S_SIDE_MUL;
                S_SIDE_MUL: state_reg <= S_SIDE_WR;
                S_SIDE_WR: begin
                    if (ax_reg == AX_Z) begin
                        state_reg <= S_FIN;
                    end else begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= S_DIV_INIT;
                    end
                end
                S_FIN: begin
                    if (status.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && s_tvalid;
        cmd.mul_sq    = (state_reg == S_SQ);
        cmd.sq_acc    = (state_reg == S_SQ) && (cnt_reg != '0);
        cmd.sqrt_init = (state_reg == S_SQRT_INIT);
        cmd.sqrt_step = (state_reg == S_SQRT);
        cmd.div_init  = (state_reg == S_DIV_INIT);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.div_end   = (state_reg == S_DIV_END);
        cmd.side_wr   = (state_reg == S_SIDE_WR);
        cmd.finish    = (state_reg == S_FIN) && status.out_free;
        cmd.start     = start_reg;
        cmd.axis      = (state_reg == S_SQ) ? cnt_reg[AX_W-1:0] : ax_reg;
    end

endmodule

// ----- rtl/core/vrdw_datapath.sv -----
// Ray setup arithmetic, walk state, step logic and the result word register.
module vrdw_datapath
    import vrdw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                op,
    input  logic                cfg_we,
    input  logic [REACH_W-1:0]  cfg_wdata,
    input  vrdw_cmd_t           cmd,
    output vrdw_status_t        status,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    logic [REACH_W-1:0]   reach_reg;
    logic                 walk_reg;
    logic [MAG_W-1:0]     mag_reg   [3];
    logic                 neg_reg   [3];
    logic [FRAC_BITS-1:0] frac_reg  [3];
    logic [CELL_W-1:0]    voxel_reg [3];
    logic [DIST_W-1:0]    delta_reg [3];
    logic [DIST_W-1:0]    side_reg  [3];
    logic [DIST_W-1:0]    travel_reg;
    logic [FACE_W-1:0]    face_reg;
    logic                 solid_reg;
    logic [SUM_W-1:0]     sum_reg, sq_v_reg, sq_r_reg, sq_bit_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic                 mv_reg, mk_reg;
    logic [M_DATA_W-1:0]  md_reg;

    logic [MAG_W-1:0]     mag_sel;
    logic                 neg_sel;
    logic [FRAC_BITS-1:0] frac_sel;
    logic [FDIST_W-1:0]   fdist;
    logic [MUL_A_W-1:0]   mul_a;
    logic [DIST_W-1:0]    mul_b;
    logic [SUM_W-1:0]     sq_try;
    logic [REM_W-1:0]     rem_sh;
    logic [63:0]          quo_ext;
    logic [PROD_W-1:0]    prod_sh;
    logic [AX_W-1:0]      wa;
    logic [DIST_W:0]      side_sum;
    logic                 go_step;
    logic [CELL_W-1:0]    nvox [3];

    always_comb begin
        unique case (cmd.axis)
            AX_Y: begin
                mag_sel = mag_reg[1]; neg_sel = neg_reg[1]; frac_sel = frac_reg[1];
            end
            AX_Z: begin
                mag_sel = mag_reg[2]; neg_sel = neg_reg[2]; frac_sel = frac_reg[2];
            end
            default: begin
                mag_sel = mag_reg[0]; neg_sel = neg_reg[0]; frac_sel = frac_reg[0];
            end
        endcase
        fdist = neg_sel ? FDIST_W'(frac_sel) : (FDIST_W'(1) << FRAC_BITS) - FDIST_W'(frac_sel);
        if (cmd.mul_sq) begin
            mul_a = MUL_A_W'(mag_sel);
            mul_b = DIST_W'(mag_sel);
        end else begin
            mul_a = MUL_A_W'(fdist);
            unique case (cmd.axis)
                AX_Y:    mul_b = delta_reg[1];
                AX_Z:    mul_b = delta_reg[2];
                default: mul_b = delta_reg[0];
            endcase
        end
        sq_try  = sq_r_reg + sq_bit_reg;
        rem_sh  = {rem_reg[REM_W-2:0], quo_reg[NUM_W-1]};
        quo_ext = 64'(quo_reg);
        prod_sh = prod_reg >> FRAC_BITS;
    end

    // axis choice: strict compares, a tie goes to the later axis (z over y over x)
    always_comb begin
        if (side_reg[0] < side_reg[1] && side_reg[0] < side_reg[2]) begin
            wa = AX_X;
        end else if (side_reg[1] < side_reg[2]) begin
            wa = AX_Y;
        end else begin
            wa = AX_Z;
        end
        side_sum = {1'b0, side_reg[wa]} + {1'b0, delta_reg[wa]};
        for (int i = 0; i < 3; i++) begin
            nvox[i] = voxel_reg[i];
        end
        nvox[wa] = voxel_reg[wa] + (neg_reg[wa] ? {CELL_W{1'b1}} : CELL_W'(1));
        go_step = cmd.start ? (reach_reg != '0) :
                  (!solid_reg && travel_reg < DIST_W'(reach_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reach_reg <= REACH_RESET;
            walk_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                reach_reg <= cfg_wdata;
            end
            if (cmd.finish) begin
                mv_reg <= 1'b1;
            end else if (m_tready) begin
                mv_reg <= 1'b0;
            end
            if (cmd.load && op == OP_START) begin
                walk_reg <= 1'b0;
            end
            if (cmd.finish) begin
                walk_reg <= !(!cmd.start && solid_reg) && go_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.load) begin
            solid_reg <= s_tdata[150];
            if (op == OP_START) begin
                sum_reg <= '0;
                for (int i = 0; i < 3; i++) begin
                    logic signed [ORG_W-1:0]  o;
                    logic signed [HEAD_W-1:0] h;
                    o = s_tdata[i*ORG_W +: ORG_W];
                    h = s_tdata[3*ORG_W + i*HEAD_W +: HEAD_W];
                    neg_reg[i]   <= h[HEAD_W-1];
                    mag_reg[i]   <= h[HEAD_W-1] ? MAG_W'(-h) : MAG_W'(h);
                    frac_reg[i]  <= o[FRAC_BITS-1:0];
                    voxel_reg[i] <= CELL_W'(o >>> FRAC_BITS);
                end
            end
        end
        if (cmd.sq_acc) begin
            sum_reg <= sum_reg + prod_reg[SUM_W-1:0];
        end
        if (cmd.sqrt_init) begin
            sq_v_reg   <= sum_reg;
            sq_r_reg   <= '0;
            sq_bit_reg <= SUM_W'(1) << (SUM_W - 2);
        end
        if (cmd.sqrt_step) begin
            if (sq_v_reg >= sq_try) begin
                sq_v_reg <= sq_v_reg - sq_try;
                sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
            end else begin
                sq_r_reg <= sq_r_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
        if (cmd.div_init) begin
            rem_reg <= '0;
            quo_reg <= {sq_r_reg[LEN_W-1:0], {FRAC_BITS{1'b0}}};
        end
        if (cmd.div_step) begin
            if (rem_sh >= REM_W'(mag_sel)) begin
                rem_reg <= rem_sh - REM_W'(mag_sel);
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
        if (cmd.div_end) begin
            if (mag_sel == '0 || quo_ext > 64'hFFFF_FFFF) begin
                delta_reg[cmd.axis] <= '1;
            end else begin
                delta_reg[cmd.axis] <= quo_ext[DIST_W-1:0];
            end
        end
        if (cmd.side_wr) begin
            if (prod_sh[PROD_W-1:DIST_W] != '0) begin
                side_reg[cmd.axis] <= '1;
            end else begin
                side_reg[cmd.axis] <= prod_sh[DIST_W-1:0];
            end
        end
        if (cmd.finish) begin
            if (!cmd.start && solid_reg) begin
                mk_reg <= KIND_RESULT;
                md_reg <= {4'b0, face_reg, 1'b1, voxel_reg[2], voxel_reg[1], voxel_reg[0]};
            end else if (go_step) begin
                travel_reg   <= side_reg[wa];
                side_reg[wa] <= side_sum[DIST_W] ? '1 : side_sum[DIST_W-1:0];
                voxel_reg    <= nvox;
                face_reg     <= face_code(wa, neg_reg[wa]);
                mk_reg       <= KIND_QUERY;
                md_reg       <= {4'b0, face_code(wa, neg_reg[wa]), 1'b0,
                                 nvox[2], nvox[1], nvox[0]};
            end else begin
                if (cmd.start) begin
                    travel_reg <= '0;
                    face_reg   <= FACE_DOWN;
                end
                mk_reg <= KIND_RESULT;
                md_reg <= '0;
            end
        end
    end

    assign status.walk_active = walk_reg;
    assign status.out_free    = !mv_reg || m_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mk_reg;

endmodule

// ----- rtl/core/voxel_ray_dda_walker_core.sv -----
// Usage notes:
// Top level of the voxel ray DDA walker.
// Input stream s_*: tuser[0] is the op (start or answer), tdata the ray origin,
// heading and solid flag. Output stream m_*: tuser[0] is the kind (query or
// final result), tdata the cell, hit and entered face.
// A start word runs setup: three squares on one multiplier, an 18-step square
// root, three 34-step restoring divisions with a side-distance multiply each,
// then one DDA step. An answer word to an active walk goes to the finish state,
// which writes its next query or result once the output register is free; then
// s_tready returns. The root is iterative and the divider is shared; one word is
// worked at a time and s_tready is high only while idle.
// A result sits in the output register until taken; the next input word is
// accepted meanwhile, and the block holds its next result until m_tready frees it.
// cfg_we/cfg_wdata write reach_limit; write only while idle.
// Reset (aresetn low, synchronous) ends any walk, empties the output register and
// sets reach_limit to 3.0.
module voxel_ray_dda_walker_core
    import vrdw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // origin_x, origin_y, origin_z, heading_x,
                                          // heading_y, heading_z, solid, pad
    input  logic [0:0]          s_tuser,  // op
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // cell_x, cell_y, cell_z, hit, face, pad
    output logic [0:0]          m_tuser,  // kind
    input  logic                cfg_we,
    input  logic [REACH_W-1:0]  cfg_wdata
);

    vrdw_cmd_t    cmd;
    vrdw_status_t status;

    vrdw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .op       (s_tuser[0]),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    vrdw_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .op        (s_tuser[0]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser[0])
    );

endmodule

// ----- rtl/core/vrdw_checker.sv -----
// Port-level checks for the walker core, bound to the top level.
module vrdw_checker
    import vrdw_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output word valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_query_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_QUERY |-> !m_tdata[48])
        else $error("query word flags a hit");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] == KIND_RESULT && !m_tdata[48] |-> m_tdata[51:0] == '0)
        else $error("miss result carries a cell or face");

endmodule

bind voxel_ray_dda_walker_core vrdw_checker u_vrdw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_voxel_ray_dda_walker_core.sv -----
// Self-checking testbench for voxel_ray_dda_walker_core: ray walks with random answers and stalls.
module tb_voxel_ray_dda_walker_core;
    import vrdw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    class dda_scoreboard;
        typedef struct packed {
            logic               kind;
            logic [CELL_W-1:0]  cx;
            logic [CELL_W-1:0]  cy;
            logic [CELL_W-1:0]  cz;
            logic               hit;
            logic [FACE_W-1:0]  face;
        } pick_t;

        pick_t              expected_q[$];
        int                 errors;
        logic               last_kind;
        logic [REACH_W-1:0] reach;
        logic               active;
        logic [CELL_W-1:0]  vox[3];
        logic [DIST_W-1:0]  side[3];
        logic [DIST_W-1:0]  delta[3];
        logic               neg[3];
        logic [FACE_W-1:0]  face_now;
        logic [DIST_W-1:0]  travel;

        function new();
            errors = 0;
            last_kind = KIND_RESULT;
            reach = REACH_RESET;
            active = 0;
            face_now = FACE_DOWN;
            travel = 0;
            for (int i = 0; i < 3; i++) begin
                vox[i] = 0; side[i] = 0; delta[i] = 0; neg[i] = 0;
            end
        endfunction

        task report(input string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        function automatic longint unsigned int_root(input longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function automatic logic [DIST_W-1:0] clamp(input longint unsigned v);
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[DIST_W-1:0];
        endfunction

        function void push(input logic k, input logic h, input logic [FACE_W-1:0] f,
                           input logic use_cell);
            pick_t p;
            p.kind = k;
            p.cx = use_cell ? vox[0] : '0;
            p.cy = use_cell ? vox[1] : '0;
            p.cz = use_cell ? vox[2] : '0;
            p.hit = h;
            p.face = f;
            expected_q = {expected_q, p};
        endfunction

        function void step_walk();
            int a;
            if (side[0] < side[1] && side[0] < side[2]) a = 0;
            else if (side[1] < side[2]) a = 1;
            else a = 2;
            travel = side[a];
            side[a] = clamp(longint'(side[a]) + longint'(delta[a]));
            vox[a] = neg[a] ? vox[a] - 1'b1 : vox[a] + 1'b1;
            case (a)
                0: face_now = neg[a] ? FACE_RIGHT : FACE_LEFT;
                1: face_now = neg[a] ? FACE_UP : FACE_DOWN;
                default: face_now = neg[a] ? FACE_FRONT : FACE_BACK;
            endcase
            push(KIND_QUERY, 1'b0, face_now, 1'b1);
        endfunction

        function void note_word(input logic op, input logic [S_DATA_W-1:0] d);
            longint unsigned mag[3], sum, len, span;
            logic signed [HEAD_W-1:0] h;
            logic [ORG_W-1:0] org;
            if (op == OP_START) begin
                sum = 0;
                for (int i = 0; i < 3; i++) begin
                    h = d[96 + i*HEAD_W +: HEAD_W];
                    neg[i] = h < 0;
                    mag[i] = neg[i] ? longint'(-longint'(h)) : longint'(h);
                    sum += mag[i] * mag[i];
                end
                len = int_root(sum);
                for (int i = 0; i < 3; i++) begin
                    org = d[i*ORG_W +: ORG_W];
                    vox[i] = org[31:16];
                    delta[i] = (mag[i] == 0) ? 32'hFFFF_FFFF : clamp((len << 16) / mag[i]);
                    span = neg[i] ? longint'(org[15:0]) : 64'd65536 - longint'(org[15:0]);
                    side[i] = clamp((span * longint'(delta[i])) >> 16);
                end
                travel = 0;
                face_now = FACE_DOWN;
                if (travel < reach) begin
                    active = 1;
                    step_walk();
                end else begin
                    active = 0;
                    push(KIND_RESULT, 1'b0, FACE_DOWN, 1'b0);
                end
            end else if (active) begin
                if (d[150]) begin
                    active = 0;
                    push(KIND_RESULT, 1'b1, face_now, 1'b1);
                end else if (travel < reach) begin
                    step_walk();
                end else begin
                    active = 0;
                    push(KIND_RESULT, 1'b0, FACE_DOWN, 1'b0);
                end
            end
        endfunction

        task check_word(input logic k, input logic [M_DATA_W-1:0] d);
            pick_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word kind=%0d data=%h", k, d));
            end else begin
                e = expected_q.pop_front();
                last_kind = k;
                if (k !== e.kind) report($sformatf("kind %0d exp %0d", k, e.kind));
                if (d[15:0] !== e.cx) report($sformatf("cell_x %h exp %h", d[15:0], e.cx));
                if (d[31:16] !== e.cy) report($sformatf("cell_y %h exp %h", d[31:16], e.cy));
                if (d[47:32] !== e.cz) report($sformatf("cell_z %h exp %h", d[47:32], e.cz));
                if (d[48] !== e.hit) report($sformatf("hit %0d exp %0d", d[48], e.hit));
                if (d[51:49] !== e.face) report($sformatf("face %0d exp %0d", d[51:49], e.face));
            end
        endtask
    endclass

    logic                aclk = 0;
    logic                aresetn = 0;
    logic                s_tvalid = 0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;  // origin_x, origin_y, origin_z, heading_x/y/z, solid, pad
    logic [0:0]          s_tuser = '0;  // op
    logic                m_tvalid;
    logic                m_tready = 0;
    logic [M_DATA_W-1:0] m_tdata;       // cell_x, cell_y, cell_z, hit, face, pad
    logic [0:0]          m_tuser;       // kind
    logic                cfg_we = 0;
    logic [REACH_W-1:0]  cfg_wdata = '0;
    logic                calm = 0;
    int                  words_sent = 0;

    dda_scoreboard sb = new();

    voxel_ray_dda_walker_core dut (.*);

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 29);
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_word(m_tuser[0], m_tdata);
            if (s_tvalid && s_tready) sb.note_word(s_tuser[0], s_tdata);
        end
    end

    task send(input logic op, input logic [31:0] ox, input logic [31:0] oy,
              input logic [31:0] oz, input logic [17:0] hx, input logic [17:0] hy,
              input logic [17:0] hz, input logic solid);
        s_tvalid <= 1;
        s_tuser <= op;
        s_tdata <= {1'b0, solid, hz, hy, hx, oz, oy, ox};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        words_sent++;
    endtask

    task rest(input int n);
        s_tvalid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    task maybe_gap();
        if (!calm && $urandom_range(0, 99) < 29) rest($urandom_range(1, 4));
    endtask

    task drain();
        rest(1);
        while (sb.expected_q.size() != 0) @(posedge aclk);
    endtask

    task set_reach(input logic [REACH_W-1:0] v);
        drain();
        repeat (20) @(posedge aclk);
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 0;
        sb.reach = v;
    endtask

    task answer(input logic solid);
        send(OP_ANSWER, $urandom, $urandom, $urandom, 18'($urandom), 18'($urandom),
             18'($urandom), solid);
    endtask

    // start a ray, then answer queries until the walk ends or max_steps
    task walk_ray(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                  input logic [17:0] hx, input logic [17:0] hy, input logic [17:0] hz,
                  input int max_steps, input int solid_pct);
        int n;
        n = 0;
        send(OP_START, ox, oy, oz, hx, hy, hz, 1'($urandom_range(0, 1)));
        drain();
        while (sb.last_kind == KIND_QUERY && n < max_steps) begin
            maybe_gap();
            answer($urandom_range(0, 99) < solid_pct);
            drain();
            n++;
        end
    endtask

    function automatic logic [31:0] rand_origin();
        if ($urandom_range(0, 3) == 0) return $urandom;
        return {{12{1'b0}}, 4'($urandom_range(0, 15)), 16'($urandom)} - 32'h0008_0000;
    endfunction

    initial begin
        #100_000_000;
        $display("** voxel_ray_dda_walker_core: FAILED **");
        $finish;
    end

    initial begin
        logic [17:0] hx, hy, hz;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed
        answer(1'b1);  // no walk: dropped
        walk_ray(32'h0001_8000, 32'h0002_4000, 32'h0000_C000, 18'h10000, 18'h08000,
                 18'h04000, 20, 0);
        walk_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 18'h1FFFF, 18'h20000,
                 18'h20000, 20, 0);
        walk_ray(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 18'h20000, 18'h1FFFF,
                 18'h00001, 3, 100);
        walk_ray(32'h0, 32'h0, 32'h0, 18'h0, 18'h0, 18'h0, 5, 0);
        walk_ray(32'h0, 32'h0, 32'h0, 18'h10000, 18'h10000, 18'h10000, 6, 0);
        walk_ray(32'h0000_4000, 32'h0, 32'h0, 18'h3F000, 18'h0, 18'h0, 4, 0);
        walk_ray(32'h0, 32'h0001_0000, 32'h0, 18'h0, 18'h10000, 18'h0, 2, 100);
        walk_ray(32'h0, 32'h0, 32'hFFFF_8000, 18'h0, 18'h0, 18'h30000, 2, 0);
        send(OP_START, 32'h0, 32'h0, 32'h0, 18'h10000, 18'h0, 18'h0, 1'b0);
        send(OP_START, 32'h0003_0000, 32'h0, 32'h0, 18'h0, 18'h10000, 18'h0, 1'b1);
        drain();
        answer(1'b1);
        drain();
        set_reach('0);
        walk_ray(32'h0001_0000, 32'h0, 32'h0, 18'h10000, 18'h0, 18'h0, 3, 0);
        answer(1'b0);
        set_reach(24'hFF_FFFF);
        walk_ray(32'h0, 32'h0, 32'h0, 18'h00001, 18'h00002, 18'h1FFFF, 6, 0);

        // random
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_reach(REACH_RESET);
                1: set_reach(24'h00_0001);
                2: set_reach(24'($urandom_range(1, 24'h0A_0000)));
                3: set_reach(24'hFF_FFFF);
                default: set_reach(24'($urandom));
            endcase
            calm = (phase == 2);
            while (words_sent < 100 * (phase + 1)) begin
                hx = 18'($urandom); hy = 18'($urandom); hz = 18'($urandom);
                if ($urandom_range(0, 9) == 0) hx = 0;
                if ($urandom_range(0, 9) == 0) hy = 0;
                if ($urandom_range(0, 9) == 0) hz = 0;
                case ($urandom_range(0, 9))
                    0: begin
                        maybe_gap();
                        answer(1'($urandom_range(0, 1)));
                    end
                    1: begin
                        maybe_gap();
                        send(OP_START, $urandom, $urandom, $urandom, hx, hy, hz,
                             1'($urandom_range(0, 1)));
                    end
                    default: begin
                        maybe_gap();
                        walk_ray(rand_origin(), rand_origin(), rand_origin(), hx, hy, hz,
                                 $urandom_range(1, 12), 12);
                    end
                endcase
            end
            calm = 0;
        end

        drain();
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** voxel_ray_dda_walker_core: PASSED **");
        end else begin
            $display("** voxel_ray_dda_walker_core: FAILED **");
        end
        $finish;
    end
endmodule

// ----- voxel_ray_dda_walker_core.f -----
rtl/core/vrdw_pkg.sv
rtl/core/vrdw_ctrl.sv
rtl/core/vrdw_datapath.sv
rtl/core/voxel_ray_dda_walker_core.sv
rtl/core/vrdw_checker.sv
tb/sv/tb_voxel_ray_dda_walker_core.sv
